>>> hdl/pf_pkg.sv
package pf_pkg;

   // Operand width of the datapath (fixed by the port widths)
   localparam int VALUE_WIDTH = 32;
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);

   // Result status codes
   localparam logic [1:0] ST_FACTOR = 2'd0;
   localparam logic [1:0] ST_ONE    = 2'd1;
   localparam logic [1:0] ST_ZERO   = 2'd2;

   typedef struct packed {
      logic                   start;
      logic [VALUE_WIDTH-1:0] dividend;
      logic [VALUE_WIDTH-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                   busy;
      logic                   done;
      logic [VALUE_WIDTH-1:0] quotient;
      logic [VALUE_WIDTH-1:0] remainder;
   } div_rsp_type;

endpackage

>>> hdl/pf_divider.sv
// Restoring divider, one quotient bit per cycle.
module pf_divider
   import pf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [VALUE_WIDTH-1:0] den_ff, den_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [VALUE_WIDTH:0]   shifted;
   logic [VALUE_WIDTH:0]   diff;

   assign shifted = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         den_in  = div_req.divisor;
         cnt_in  = CNT_WIDTH'(VALUE_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[VALUE_WIDTH]) begin
            rem_in = diff[VALUE_WIDTH-1:0];
         end else begin
            rem_in = shifted[VALUE_WIDTH-1:0];
         end
         quo_in = {quo_ff[VALUE_WIDTH-2:0], ~diff[VALUE_WIDTH]};
         cnt_in = cnt_ff - CNT_WIDTH'(1);
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

>>> hdl/prime_factorizer.sv
// Trial-division prime factorizer. Each accepted value yields its prime
// factors in ascending order, one rsp transaction per factor, with
// position counting from 0 and last set on the final one. Zero gives a
// single status-2 transaction and one a single status-1 transaction. The
// block takes one value at a time: req_ready is high only while idle. Cost
// per value: a pass through S_TWOS per factor of two, then one pass of the
// restoring divider per odd trial divisor or found factor; the divider sets
// the rate. A 32-bit prime near 2^32 needs about 32768 trial divisors.
// Results wait in a holding slot and an output register, so a stalled rsp
// side holds the sequencer when a new factor finds both full, or when a
// special or last result finds the output register full.
module prime_factorizer
   import pf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_factor,
   output logic [4:0]  rsp_position,
   output logic        rsp_last,
   output logic [1:0]  rsp_status
);

   // Sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SPECIAL = 3'd1;  // zero or one input
   localparam logic [2:0] S_TWOS    = 3'd2;  // strip factors of two
   localparam logic [2:0] S_DIVGO   = 3'd3;  // launch remainder / divisor
   localparam logic [2:0] S_DIVWAIT = 3'd4;
   localparam logic [2:0] S_EVAL    = 3'd5;  // act on quotient and remainder
   localparam logic [2:0] S_FINAL   = 3'd6;  // leftover prime
   localparam logic [2:0] S_FLUSH   = 3'd7;  // send held factor with last

   logic [2:0]             state_ff, state_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;       // cofactor still to divide
   logic [VALUE_WIDTH-1:0] div_ff, div_in;       // trial divisor
   logic [5:0]             count_ff, count_in;   // factors found so far

   // Holding slot: the newest factor waits here until the next one shows
   // whether it is the last.
   logic                   pend_valid_ff, pend_valid_in;
   logic [31:0]            pend_factor_ff, pend_factor_in;
   logic [4:0]             pend_pos_ff, pend_pos_in;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            rsp_factor_ff, rsp_factor_in;
   logic [4:0]             rsp_position_ff, rsp_position_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;

   logic                   out_free;
   logic                   push_req;
   logic [31:0]            push_val;
   logic                   push_ok;
   logic                   out_load;

   div_req_type            div_req;
   div_rsp_type            div_rsp;

   pf_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign push_ok   = !pend_valid_ff || out_free;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in         = state_ff;
      rem_in           = rem_ff;
      div_in           = div_ff;
      count_in         = count_ff;
      pend_valid_in    = pend_valid_ff;
      pend_factor_in   = pend_factor_ff;
      pend_pos_in      = pend_pos_ff;
      rsp_factor_in    = rsp_factor_ff;
      rsp_position_in  = rsp_position_ff;
      rsp_last_in      = rsp_last_ff;
      rsp_status_in    = rsp_status_ff;
      push_req         = 1'b0;
      push_val         = '0;
      out_load         = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = rem_ff;
      div_req.divisor  = div_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rem_in   = req_value;
               count_in = '0;
               if (req_value inside {32'd0, 32'd1}) begin
                  state_in = S_SPECIAL;
               end else begin
                  state_in = S_TWOS;
               end
            end
         end
         S_SPECIAL: begin
            if (out_free) begin
               out_load        = 1'b1;
               rsp_factor_in   = '0;
               rsp_position_in = '0;
               rsp_last_in     = 1'b1;
               rsp_status_in   = (rem_ff == '0) ? ST_ZERO : ST_ONE;
               state_in        = S_IDLE;
            end
         end
         S_TWOS: begin
            if (!rem_ff[0]) begin
               push_req = 1'b1;
               push_val = 32'd2;
               if (push_ok) begin
                  rem_in = rem_ff >> 1;
               end
            end else begin
               div_in   = VALUE_WIDTH'(3);
               state_in = S_DIVGO;
            end
         end
         S_DIVGO: begin
            div_req.start = 1'b1;
            state_in      = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (div_rsp.done) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            // divisor <= remainder / divisor, i.e. divisor squared fits
            if (div_ff <= div_rsp.quotient) begin
               if (div_rsp.remainder == '0) begin
                  push_req = 1'b1;
                  push_val = div_ff;
                  if (push_ok) begin
                     rem_in   = div_rsp.quotient;
                     state_in = S_DIVGO;
                  end
               end else begin
                  div_in   = div_ff + VALUE_WIDTH'(2);
                  state_in = S_DIVGO;
               end
            end else begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            if (rem_ff > VALUE_WIDTH'(2)) begin
               push_req = 1'b1;
               push_val = rem_ff;
               if (push_ok) begin
                  state_in = S_FLUSH;
               end
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               out_load        = 1'b1;
               rsp_factor_in   = pend_factor_ff;
               rsp_position_in = pend_pos_ff;
               rsp_last_in     = 1'b1;
               rsp_status_in   = ST_FACTOR;
               pend_valid_in   = 1'b0;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // New factor: held one moves out (not last), new one takes the slot
      if (push_req && push_ok) begin
         if (pend_valid_ff) begin
            out_load        = 1'b1;
            rsp_factor_in   = pend_factor_ff;
            rsp_position_in = pend_pos_ff;
            rsp_last_in     = 1'b0;
            rsp_status_in   = ST_FACTOR;
         end
         pend_valid_in  = 1'b1;
         pend_factor_in = push_val;
         pend_pos_in    = count_ff[4:0];
         count_in       = count_ff + 6'd1;
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rem_ff        <= '0;
         div_ff        <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rem_ff        <= rem_in;
         div_ff        <= div_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_factor_ff  <= pend_factor_in;
      pend_pos_ff     <= pend_pos_in;
      rsp_factor_ff   <= rsp_factor_in;
      rsp_position_ff <= rsp_position_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_status_ff   <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_factor   = rsp_factor_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_status   = rsp_status_ff;

   // Special results are single, zero-factor transactions
   a_special_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_FACTOR) |->
         rsp_last && (rsp_factor == '0) && (rsp_position == '0))
      else $error("special result malformed");

   // Divider completion only while the sequencer waits for it
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIVWAIT))
      else $error("divider done outside wait state");

   // Divider runs only while the sequencer waits for it
   a_div_busy_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.busy |-> (state_ff == S_DIVWAIT))
      else $error("divider busy outside wait state");

   // Trial divisor stays odd while dividing
   a_div_odd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVGO || state_ff == S_DIVWAIT || state_ff == S_EVAL) |->
         div_ff[0])
      else $error("even trial divisor");

   // Every factoring run holds a factor when it flushes
   a_flush_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH) |-> pend_valid_ff)
      else $error("flush with empty holding slot");

   // No new value while a run is in progress
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accept");

endmodule
